// File: hdl/bis_pkg.sv
// Package for the binary insertion sorter: sizes, element type, cell control
// struct and controller state enum. No dependencies.
`default_nettype none

package bis_pkg;

  localparam int unsigned DEPTH      = 64;
  localparam int unsigned ELEM_WIDTH = 32;
  localparam int unsigned DATA_BYTES = (ELEM_WIDTH + 7) / 8;
  localparam int unsigned TDATA_W    = DATA_BYTES * 8;

  typedef logic signed [ELEM_WIDTH-1:0] elem_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic ins_en;  // insert the broadcast element
    logic pop_en;  // shift the chain one place towards cell 0
  } cell_ctrl_t;

  typedef enum logic {
    ST_FILL,
    ST_EMIT
  } state_e;

endpackage

`default_nettype wire

// File: hdl/bis_cell.sv
// One compare-and-shift cell of the sorting chain: holds one element and its
// valid bit. Depends on bis_pkg.
`default_nettype none

module bis_cell (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  bis_pkg::cell_ctrl_t ctrl_i,
  input  bis_pkg::elem_t      new_val_i,
  input  bis_pkg::elem_t      left_val_i,
  input  wire                 left_vld_i,
  input  wire                 left_ins_i,
  input  bis_pkg::elem_t      right_val_i,
  input  wire                 right_vld_i,
  output bis_pkg::elem_t      val_o,
  output logic                vld_o,
  output logic                ins_o
);
  import bis_pkg::*;

  elem_t val_q, val_d;
  logic  vld_q, vld_d;

  // empty, or stored element not smaller than the arriving one
  assign ins_o = !vld_q || !(val_q < new_val_i);
  assign val_o = val_q;
  assign vld_o = vld_q;

  always_comb begin
    val_d = val_q;
    vld_d = vld_q;
    if (ctrl_i.ins_en && ins_o) begin
      if (left_ins_i) begin
        val_d = left_val_i;
        vld_d = left_vld_i;
      end else begin
        val_d = new_val_i;
        vld_d = 1'b1;
      end
    end else if (ctrl_i.pop_en) begin
      val_d = right_val_i;
      vld_d = right_vld_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

`default_nettype wire

// File: hdl/binary_insertion_sorter.sv
// Top level of the binary insertion sorter: controller and a chain of DEPTH
// bis_cell instances. Depends on bis_pkg and bis_cell.
//
//  channel  | dir | payload                         | marker
//  s_axis   | in  | tdata: value                    | tlast: last
//  m_axis   | out | tdata: sorted_value             | tlast: last_out, tuser: overflow
//
// Fill: one element accepted per cycle; every cell compares in parallel and
// the chain opens a gap in the same cycle. On a tlast element the chain
// switches to emit: one result per cycle from cell 0, the chain shifting down;
// s_axis_tready_o stays low until the last result is taken. m_axis stalls
// simply hold the chain. Reset empties every cell.
`default_nettype none

module binary_insertion_sorter (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  wire  [bis_pkg::TDATA_W-1:0]    s_axis_tdata_i,   // [ELEM_WIDTH-1:0] value
  input  wire                            s_axis_tlast_i,
  output logic                           m_axis_tvalid_o,
  input  wire                            m_axis_tready_i,
  output logic [bis_pkg::TDATA_W-1:0]    m_axis_tdata_o,   // [ELEM_WIDTH-1:0] sorted_value
  output logic                           m_axis_tlast_o,
  output logic                           m_axis_tuser_o    // [0] overflow
);
  import bis_pkg::*;

  state_e     state_q, state_d;
  logic       dropped_q, dropped_d;
  cell_ctrl_t ctrl;
  logic       in_acc, out_acc, full;
  elem_t      new_val;

  elem_t      cell_val [DEPTH];
  logic       cell_vld [DEPTH];
  logic       cell_ins [DEPTH];

  assign new_val = elem_t'(s_axis_tdata_i[ELEM_WIDTH-1:0]);
  assign full    = cell_vld[DEPTH-1];
  assign in_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_acc = m_axis_tvalid_o && m_axis_tready_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_FILL: if (in_acc && s_axis_tlast_i) state_d = ST_EMIT;
      ST_EMIT: if (out_acc && m_axis_tlast_o) state_d = ST_FILL;
      default: state_d = ST_FILL;
    endcase
  end

  // outputs
  always_comb begin
    s_axis_tready_o = 1'b0;
    m_axis_tvalid_o = 1'b0;
    ctrl            = '0;
    case (state_q)
      ST_FILL: begin
        s_axis_tready_o = 1'b1;
        ctrl.ins_en     = in_acc && !full;
      end
      ST_EMIT: begin
        m_axis_tvalid_o = cell_vld[0];
        ctrl.pop_en     = out_acc;
      end
      default: ;
    endcase
  end

  always_comb begin
    dropped_d = dropped_q;
    if (in_acc && full) dropped_d = 1'b1;
    if (out_acc && m_axis_tlast_o) dropped_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_FILL;
      dropped_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      dropped_q <= dropped_d;
    end
  end

  assign m_axis_tdata_o = TDATA_W'($unsigned(cell_val[0]));
  assign m_axis_tlast_o = !cell_vld[1];
  assign m_axis_tuser_o = dropped_q;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    elem_t l_val, r_val;
    logic  l_vld, l_ins, r_vld;
    if (i == 0) begin : g_first
      assign l_val = '0;
      assign l_vld = 1'b0;
      assign l_ins = 1'b0;
    end else begin : g_mid
      assign l_val = cell_val[i-1];
      assign l_vld = cell_vld[i-1];
      assign l_ins = cell_ins[i-1];
    end
    if (i == DEPTH-1) begin : g_top
      assign r_val = '0;
      assign r_vld = 1'b0;
    end else begin : g_below
      assign r_val = cell_val[i+1];
      assign r_vld = cell_vld[i+1];
    end
    bis_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .new_val_i   (new_val),
      .left_val_i  (l_val),
      .left_vld_i  (l_vld),
      .left_ins_i  (l_ins),
      .right_val_i (r_val),
      .right_vld_i (r_vld),
      .val_o       (cell_val[i]),
      .vld_o       (cell_vld[i]),
      .ins_o       (cell_ins[i])
    );
  end

  a_emit_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT |-> m_axis_tvalid_o)
    else $error("emit with empty chain");

  a_drop_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FILL && dropped_q) |-> full)
    else $error("overflow flag without full chain");

  a_last_ends_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && m_axis_tlast_o) |=> (state_q == ST_FILL && !cell_vld[0] && !dropped_q))
    else $error("chain not empty after final result");

  a_no_in_during_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> (state_q == ST_FILL && !m_axis_tvalid_o))
    else $error("input taken while emitting");

endmodule

`default_nettype wire

// File: sim/tb_binary_insertion_sorter.sv
`timescale 1ns / 100ps
// Testbench for binary_insertion_sorter: streams sets of signed elements in,
// predicts each sorted burst and checks it on the master stream field by field.
// Depends on bis_pkg and the binary_insertion_sorter RTL.
`default_nettype none

module tb_binary_insertion_sorter;

  import bis_pkg::*;

  localparam int unsigned WDOG_LIMIT = 3000;
  localparam int unsigned TAIL_CYCLES = DEPTH + 8;

  typedef struct packed {
    elem_t value;
    logic  last;
    logic  ovf;
  } sorted_res_t;

  logic               clk_i;
  logic               rst_ni;
  logic               s_valid;
  logic               s_tready;
  logic [TDATA_W-1:0] s_tdata;
  logic               s_last;
  logic               m_tvalid;
  logic               m_tready;
  logic [TDATA_W-1:0] m_tdata;
  logic               m_tlast;
  logic               m_tuser;

  // prediction state
  elem_t       sort_store[$];
  bit          elem_dropped;
  sorted_res_t sorted_exp_q[$];

  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;
  int unsigned err_cnt;
  int unsigned idle_cycles;

  binary_insertion_sorter DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),   // [ELEM_WIDTH-1:0] value
    .s_axis_tlast_i  (s_last),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),   // [ELEM_WIDTH-1:0] sorted_value
    .m_axis_tlast_o  (m_tlast),
    .m_axis_tuser_o  (m_tuser)    // [0] overflow
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  task automatic report_err(input string msg);
    $display("%0t ERROR: %s", $realtime, msg);
    err_cnt++;
  endtask

  // insert before the first entry that is not smaller; burst out on last
  function automatic void predict_elem(input elem_t v, input bit l);
    int unsigned pos;
    sorted_res_t res;
    if (sort_store.size() < DEPTH) begin
      pos = 0;
      while (pos < sort_store.size() && sort_store[pos] < v) pos++;
      sort_store.insert(pos, v);
    end else begin
      elem_dropped = 1'b1;
    end
    if (l) begin
      foreach (sort_store[k]) begin
        res.value = sort_store[k];
        res.last  = (k == sort_store.size() - 1);
        res.ovf   = elem_dropped;
        sorted_exp_q.push_back(res);
      end
      sort_store.delete();
      elem_dropped = 1'b0;
    end
  endfunction

  function automatic elem_t rand_elem();
    elem_t v;
    case ($urandom_range(9))
      5, 6, 7: v = elem_t'(int'($urandom_range(8)) - 4);
      8:       v = $urandom_range(1) ? {1'b1, {(ELEM_WIDTH-1){1'b0}}}
                                     : {1'b0, {(ELEM_WIDTH-1){1'b1}}};
      9:       v = {$urandom_range(1) ? 2'b10 : 2'b01, (ELEM_WIDTH-2)'($urandom)};
      default: v = elem_t'($urandom);
    endcase
    return v;
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_elem(input elem_t v, input bit l);
    while ($urandom_range(99) < src_idle_pct) begin
      s_valid = 1'b0;
      @(negedge clk_i);
    end
    s_valid = 1'b1;
    s_tdata = '0;
    s_tdata[ELEM_WIDTH-1:0] = v;
    s_last = l;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    predict_elem(v, l);
    @(negedge clk_i);
    s_valid = 1'b0;
  endtask

  task automatic wait_drained();
    wait (sorted_exp_q.size() == 0);
    @(negedge clk_i);
  endtask

  task automatic test_extremes();
    send_elem({1'b0, {(ELEM_WIDTH-1){1'b1}}}, 1'b0);
    send_elem({1'b1, {(ELEM_WIDTH-1){1'b0}}}, 1'b0);
    send_elem('0, 1'b0);
    send_elem('1, 1'b0);
    send_elem(elem_t'(1), 1'b0);
    send_elem({1'b1, {(ELEM_WIDTH-2){1'b0}}, 1'b1}, 1'b0);
    send_elem({1'b0, {(ELEM_WIDTH-2){1'b1}}, 1'b0}, 1'b0);
    send_elem(elem_t'(32'h5555_aaaa), 1'b1);
  endtask

  task automatic test_single_and_dups();
    send_elem(elem_t'(-7), 1'b1);
    send_elem(elem_t'(5), 1'b0);
    send_elem(elem_t'(-3), 1'b0);
    send_elem(elem_t'(5), 1'b0);
    send_elem(elem_t'(5), 1'b0);
    send_elem(elem_t'(-3), 1'b1);
    // already ascending, then descending
    for (int i = 0; i < 4; i++) send_elem(elem_t'(i), 1'b0);
    for (int i = 4; i > 0; i--) send_elem(elem_t'(i - 2), i == 1);
  endtask

  // exactly full: no element lost
  task automatic test_store_full();
    for (int i = 0; i < DEPTH; i++) send_elem(rand_elem(), i == DEPTH - 1);
  endtask

  // past full, the final element itself dropped
  task automatic test_overflow();
    for (int i = 0; i < DEPTH + 3; i++) send_elem(rand_elem(), i == DEPTH + 2);
  endtask

  task automatic test_random(input int unsigned n_items);
    int unsigned sent;
    int unsigned set_len;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) == 0) set_len = $urandom_range(DEPTH + 4, 9);
      else set_len = $urandom_range(8, 1);
      if (set_len > n_items - sent) set_len = n_items - sent;
      for (int i = 0; i < set_len; i++) send_elem(rand_elem(), i == set_len - 1);
      sent += set_len;
      if ($urandom_range(5) == 0) wait_drained();
    end
  endtask

  // receiver stalls
  always @(negedge clk_i) begin
    m_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  always @(posedge clk_i) begin
    sorted_res_t exp;
    if (m_tvalid && m_tready) begin
      if (sorted_exp_q.size() == 0) begin
        report_err($sformatf("unexpected result value=%0d last=%0b ovf=%0b",
                             $signed(m_tdata[ELEM_WIDTH-1:0]), m_tlast, m_tuser));
      end else begin
        exp = sorted_exp_q.pop_front();
        if (m_tdata[ELEM_WIDTH-1:0] !== exp.value)
          report_err($sformatf("sorted_value %0d, expected %0d",
                               $signed(m_tdata[ELEM_WIDTH-1:0]), exp.value));
        if (m_tlast !== exp.last)
          report_err($sformatf("last_out %0b, expected %0b", m_tlast, exp.last));
        if (m_tuser !== exp.ovf)
          report_err($sformatf("overflow %0b, expected %0b", m_tuser, exp.ovf));
      end
    end
  end

  // watchdog: cycles without any transaction
  always @(posedge clk_i) begin
    if ((s_valid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("binary_insertion_sorter test failed");
      $finish;
    end
  end

  initial begin
    s_valid = 1'b0;
    s_tdata = '0;
    s_last = 1'b0;
    m_tready = 1'b0;
    rst_ni = 1'b0;
    err_cnt = 0;
    idle_cycles = 0;
    elem_dropped = 1'b0;
    src_idle_pct = 13;
    sink_idle_pct = 45;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_extremes();
    test_single_and_dups();
    test_store_full();
    wait_drained();
    test_overflow();
    test_random(6);
    wait_drained();

    src_idle_pct = 45;
    sink_idle_pct = 13;
    test_random(6);
    wait_drained();

    src_idle_pct = 0;
    sink_idle_pct = 0;
    test_random(5);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sorted_exp_q.size() != 0)
      report_err($sformatf("%0d results never arrived", sorted_exp_q.size()));
    if (err_cnt == 0) begin
      $display("binary_insertion_sorter test passed");
    end else begin
      $display("binary_insertion_sorter test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
